[sv/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int CAPACITY = 16;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_SERVE = 1'b1;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_SERVED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic        operation;
        logic [15:0] entry_id;
        logic [7:0]  urgency;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] served_id;
        logic [4:0]  fill_count;
    } t_result;

    // one queue position as held by a cell
    typedef struct packed {
        logic        valid;
        logic [15:0] id;
        logic [7:0]  urg;
    } t_slot;

    // command broadcast to every cell
    typedef struct packed {
        logic        push;
        logic        serve;
        logic [15:0] id;
        logic [7:0]  urg;
    } t_bcast;

endpackage
`default_nettype wire

[sv/spq_cell.sv]
// One compare-and-shift cell of the queue chain.
`default_nettype none
module spq_cell
    import spq_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_head,
    input  wire t_bcast i_bcast,
    input  wire t_slot  i_left,
    input  wire t_slot  i_right,
    input  wire logic   i_left_ins,
    output logic        o_ins,
    output t_slot       o_slot
);

    logic        r_valid;
    logic [15:0] r_id;
    logic [7:0]  r_urg;

    // head takes the new entry only on a strictly greater urgency,
    // later positions on greater or equal
    always_comb begin
        if (!r_valid) begin
            o_ins = 1'b1;
        end else if (i_head) begin
            o_ins = i_bcast.urg > r_urg;
        end else begin
            o_ins = r_urg <= i_bcast.urg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_bcast.serve) begin
            r_valid <= i_right.valid;
        end else if (i_bcast.push) begin
            if (i_left_ins) begin
                r_valid <= i_left.valid;
            end else if (o_ins) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bcast.serve) begin
            r_id  <= i_right.id;
            r_urg <= i_right.urg;
        end else if (i_bcast.push) begin
            if (i_left_ins) begin
                r_id  <= i_left.id;
                r_urg <= i_left.urg;
            end else if (o_ins) begin
                r_id  <= i_bcast.id;
                r_urg <= i_bcast.urg;
            end
        end
    end

    assign o_slot = '{valid: r_valid, id: r_id, urg: r_urg};

    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_right.valid |-> r_valid)
        else $error("hole in valid chain");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_right.valid) |-> (r_urg >= i_right.urg))
        else $error("queue order broken");

    a_ins_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_left_ins |-> o_ins)
        else $error("insertion flag not monotonic along chain");

endmodule
`default_nettype wire

[sv/sorted_priority_queue_top.sv]
// Sorted priority queue: chain of compare-and-shift cells with result register.
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+-----------------------------------
//  command  | start, busy, i_item       | taken when start && !busy
//  result   | o_valid, o_result         | one-cycle strobe, no back-pressure
//
// No word waits on another: all cells compare against the broadcast urgency
// and shift in parallel, so busy stays low and a word may follow each cycle.
// The result appears on the cycle after the command is taken.
// Synchronous active-low reset empties the chain by clearing the valid bits.
// Entry payload is not reset; empty positions are never reported.
`default_nettype none
module sorted_priority_queue_top
    import spq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire t_item i_item,
    output logic       o_valid,
    output t_result    o_result
);

    // position 0 and CAPACITY+1 are empty boundary slots
    t_slot  w_lslot [CAPACITY+2];
    logic   w_ins   [CAPACITY+1];
    t_bcast w_bcast;

    logic       w_take;
    logic       w_full;
    logic       w_empty;
    logic       r_valid;
    t_result    r_result;
    logic [4:0] r_fill;
    logic [4:0] n_fill;
    t_result    n_result;

    assign busy    = 1'b0;
    assign w_take  = start && !busy;
    assign w_full  = w_lslot[CAPACITY].valid;
    assign w_empty = !w_lslot[1].valid;

    assign w_lslot[0]          = '0;
    assign w_lslot[CAPACITY+1] = '0;
    assign w_ins[0]            = 1'b0;

    assign w_bcast.push  = w_take && (i_item.operation == OP_PUSH) && !w_full;
    assign w_bcast.serve = w_take && (i_item.operation == OP_SERVE) && !w_empty;
    assign w_bcast.id    = i_item.entry_id;
    assign w_bcast.urg   = i_item.urgency;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_head     (1'(g == 0)),
            .i_bcast    (w_bcast),
            .i_left     (w_lslot[g]),
            .i_right    (w_lslot[g+2]),
            .i_left_ins (w_ins[g]),
            .o_ins      (w_ins[g+1]),
            .o_slot     (w_lslot[g+1])
        );
    end

    always_comb begin
        n_fill             = r_fill;
        n_result.status    = ST_PUSHED;
        n_result.served_id = '0;
        if (i_item.operation == OP_SERVE) begin
            if (w_empty) begin
                n_result.status = ST_EMPTY;
            end else begin
                n_result.status    = ST_SERVED;
                n_result.served_id = w_lslot[1].id;
                n_fill             = r_fill - 5'd1;
            end
        end else if (w_full) begin
            n_result.status = ST_FULL;
        end else begin
            n_fill = r_fill + 5'd1;
        end
        n_result.fill_count = n_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fill  <= '0;
        end else begin
            r_valid <= w_take;
            if (w_take) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> o_valid)
        else $error("taken word gave no result");

    a_fill_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.fill_count == r_fill))
        else $error("reported fill differs from held count");

    a_empty_serve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (i_item.operation == OP_SERVE) && w_empty) |=>
        (o_result.status == ST_EMPTY && o_result.fill_count == 5'd0))
        else $error("serve on empty misreported");

endmodule
`default_nettype wire

[tb/sorted_priority_queue_top_tb.sv]
// Self-checking testbench for the priority queue: driver, queue predictor, result checker.
module sorted_priority_queue_top_tb;
    import spq_pkg::*;

    localparam int RANDOM_WORDS = 1000;
    localparam int IDLE_PCT     = 30;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 8;
    localparam int REPORT_MAX   = 10;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_TIES} t_mix;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    t_item   command_words[$];
    t_result awaited_results[$];

    int words_issued = 0;
    int words_taken  = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    // predictor copy of the queue, head at index 0
    logic [15:0] model_ids  [CAPACITY];
    logic [7:0]  model_urgs [CAPACITY];
    int          model_fill = 0;

    sorted_priority_queue_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void add_word(input logic op, input logic [15:0] id,
                                     input logic [7:0] urg);
        t_item w;
        w.operation = op;
        w.entry_id  = id;
        w.urgency   = urg;
        command_words.push_back(w);
    endfunction

    function automatic t_result step_queue(input t_item w);
        t_result r;
        int      slot;
        r = '0;
        if (w.operation == OP_SERVE) begin
            if (model_fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.status    = ST_SERVED;
                r.served_id = model_ids[0];
                for (int i = 1; i < model_fill; i++) begin
                    model_ids[i-1]  = model_ids[i];
                    model_urgs[i-1] = model_urgs[i];
                end
                model_fill--;
            end
        end else if (model_fill >= CAPACITY) begin
            r.status = ST_FULL;
        end else begin
            // only a strictly higher urgency displaces the head
            if (model_fill == 0 || w.urgency > model_urgs[0]) begin
                slot = 0;
            end else begin
                slot = 1;
                while (slot < model_fill && model_urgs[slot] > w.urgency)
                    slot++;
            end
            for (int i = model_fill; i > slot; i--) begin
                model_ids[i]  = model_ids[i-1];
                model_urgs[i] = model_urgs[i-1];
            end
            model_ids[slot]  = w.entry_id;
            model_urgs[slot] = w.urgency;
            model_fill++;
            r.status = ST_PUSHED;
        end
        r.fill_count = model_fill[4:0];
        return r;
    endfunction

    // driver: a word held on the bus stays until taken
    always @(posedge i_clk) begin : driver
        logic calm;
        calm = words_issued >= 350 && words_issued < 600;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (command_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                start  <= 1'b1;
                i_item <= command_words.pop_front();
                words_issued++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predict on every taken word, then check any result strobe
    always @(posedge i_clk) begin : monitor
        t_result want;
        logic    took;
        if (i_rst_n) begin
            took = start && !busy;
            if (took) begin
                awaited_results.push_back(step_queue(i_item));
                words_taken++;
            end
            if (o_valid) begin
                if (awaited_results.size() == 0) begin
                    if (mismatches < REPORT_MAX)
                        $display("unexpected result: status %0d id %h fill %0d",
                                 o_result.status, o_result.served_id, o_result.fill_count);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (want.status !== o_result.status
                            || want.served_id !== o_result.served_id
                            || want.fill_count !== o_result.fill_count) begin
                        if (mismatches < REPORT_MAX)
                            $display("mismatch (exp/act): status %0d/%0d id %h/%h fill %0d/%0d",
                                     want.status, o_result.status,
                                     want.served_id, o_result.served_id,
                                     want.fill_count, o_result.fill_count);
                        mismatches++;
                    end
                end
            end
            if (took || o_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin : run
        int          k;
        int          span;
        int          push_pct;
        int          directed_words;
        t_mix        mix;
        logic [7:0]  u;

        add_word(OP_SERVE, 16'hFFFF, 8'hFF);   // serve while empty
        add_word(OP_PUSH,  16'h0000, 8'h00);
        add_word(OP_PUSH,  16'hFFFF, 8'hFF);   // beats head, goes to front
        add_word(OP_PUSH,  16'h1234, 8'hFF);   // ties head, lands second
        add_word(OP_PUSH,  16'hABCD, 8'h00);   // ties older zero, goes ahead of it
        for (k = 0; k < CAPACITY - 4; k++)
            add_word(OP_PUSH, (k % 2) ? 16'h5555 : (16'hAAAA ^ 16'(k)), 8'(k * 23));
        add_word(OP_PUSH, 16'h0F0F, 8'h80);    // store full: dropped
        repeat (5) add_word(OP_SERVE, 16'h0000, 8'h00);
        directed_words = command_words.size();

        // phases biased towards filling, draining, an even mix or tied urgencies
        while (command_words.size() < directed_words + RANDOM_WORDS) begin
            mix  = t_mix'($urandom_range(3));
            span = $urandom_range(8, 48);
            case (mix)
                MIX_FILL:  push_pct = 85;
                MIX_DRAIN: push_pct = 15;
                MIX_EVEN:  push_pct = 50;
                default:   push_pct = 60;
            endcase
            repeat (span) begin
                if (mix == MIX_TIES)
                    u = 8'($urandom_range(3)) ^ ($urandom_range(1) ? 8'hFC : 8'h00);
                else if ($urandom_range(7) == 0)
                    u = $urandom_range(1) ? 8'hFF : 8'h00;
                else
                    u = 8'($urandom);
                add_word(($urandom_range(99) < push_pct) ? OP_PUSH : OP_SERVE,
                         16'($urandom), u);
            end
        end
        k = command_words.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken < k || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
